// File: rtl/core/photogate_interval_timer_top_assert.svh
// Assertion macros used by the checker module.
`ifndef PHOTOGATE_INTERVAL_TIMER_TOP_ASSERT_SVH
`define PHOTOGATE_INTERVAL_TIMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PTIMER_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTIMER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ptimer_pkg.sv
package ptimer_pkg;

    // History store geometry
    localparam int HIST_DEPTH = 64;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);

    typedef logic [HIST_AW-1:0] hist_addr_t;
    typedef logic [HIST_CW-1:0] hist_cnt_t;

    // Operation codes carried in s_tuser
    typedef enum logic [2:0] {
        OP_EDGE   = 3'd0,
        OP_STOP   = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_BROWSE = 3'd3,
        OP_RESUME = 3'd4
    } op_t;

    // Mode codes (2 and 3 behave as counting)
    localparam logic [1:0] MODE_BLOCK    = 2'd0;
    localparam logic [1:0] MODE_INTERVAL = 2'd1;

    localparam logic [1:0]  GATE_NONE     = 2'd3;
    localparam logic [7:0]  SEQ_MAX       = 8'd255;
    localparam logic [7:0]  SEQ_START     = 8'd1;
    localparam logic [23:0] MIN_TICKS_RST = 24'd600;

    // Configuration register map (byte address 4*i)
    localparam int APB_AW = 3;
    localparam logic [0:0] REG_MODE = 1'b0;
    localparam logic [0:0] REG_MIN  = 1'b1;

    // Stream packing
    localparam int IN_FIELDS_W  = 2 + 1 + 32;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + 1 + 1 + 2 + 32 + 32 + HIST_CW + HIST_AW + 8 + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Bit offsets of result fields in m_tdata
    localparam int OB_RUN   = 0;
    localparam int OB_STOP  = 1;
    localparam int OB_BRW   = 2;
    localparam int OB_GATE  = 3;
    localparam int OB_SHOWN = 5;
    localparam int OB_START = 37;
    localparam int OB_CNT   = 69;
    localparam int OB_VIEW  = OB_CNT + HIST_CW;
    localparam int OB_SEQ   = OB_VIEW + HIST_AW;
    localparam int OB_SAVED = OB_SEQ + 8;

    // History memory request
    typedef struct packed {
        logic        we;
        hist_addr_t  waddr;
        logic [31:0] wdata;
        logic        re;
        hist_addr_t  raddr;
    } hist_req_t;

    // One result transaction
    typedef struct packed {
        logic        running;
        logic        stopped;
        logic        browsing;
        logic [1:0]  gate;
        logic [31:0] shown;
        logic [31:0] start;
        hist_cnt_t   count;
        hist_addr_t  view;
        logic [7:0]  seq;
        logic        saved;
    } result_t;

    // Ring slot of a logical position: base + offset modulo depth
    function automatic hist_addr_t slot_of(hist_addr_t base, hist_cnt_t off);
        logic [HIST_CW:0] sum;
        sum = {{(HIST_CW + 1 - HIST_AW){1'b0}}, base} + {1'b0, off};
        if (sum >= (HIST_CW + 1)'(HIST_DEPTH)) begin
            sum = sum - (HIST_CW + 1)'(HIST_DEPTH);
        end
        return sum[HIST_AW-1:0];
    endfunction

endpackage

// File: rtl/core/ptimer_hist_ram.sv
module ptimer_hist_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/ptimer_ctrl.sv
module ptimer_ctrl import ptimer_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  logic [2:0]  op,
    input  logic [1:0]  gate,
    input  logic        active,
    input  logic [31:0] tick,
    input  logic [1:0]  mode,
    input  logic [23:0] min_ticks,
    output hist_req_t   req,
    output result_t     res,
    output logic        use_mem
);

    logic        running_reg, running_next;
    logic        stopped_reg, stopped_next;
    logic        browse_reg, browse_next;
    logic [1:0]  owner_reg, owner_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] last_reg, last_next;
    logic [31:0] ecount_reg, ecount_next;
    hist_addr_t  oldest_reg, oldest_next;
    hist_cnt_t   held_reg, held_next;
    hist_addr_t  bidx_reg, bidx_next;
    logic [7:0]  seq_reg, seq_next;

    logic        store;
    logic        saved;
    logic [31:0] dur;
    hist_addr_t  waddr;
    hist_cnt_t   held_less;
    hist_cnt_t   bidx_inc;

    // Next-state logic for one transaction
    always_comb begin
        running_next = running_reg;
        stopped_next = stopped_reg;
        browse_next  = browse_reg;
        owner_next   = owner_reg;
        start_next   = start_reg;
        last_next    = last_reg;
        ecount_next  = ecount_reg;
        oldest_next  = oldest_reg;
        held_next    = held_reg;
        bidx_next    = bidx_reg;
        seq_next     = seq_reg;
        store        = 1'b0;
        saved        = 1'b0;
        waddr        = oldest_reg;
        dur          = tick - start_reg;
        held_less    = '0;
        bidx_inc     = hist_cnt_t'(bidx_reg) + hist_cnt_t'(1);

        case (op)
            OP_EDGE: begin
                if (!stopped_reg) begin
                    if (mode == MODE_BLOCK) begin
                        if (!gate[1]) begin
                            if (!running_reg) begin
                                if (active) begin
                                    running_next = 1'b1;
                                    owner_next   = gate;
                                    browse_next  = 1'b0;
                                    start_next   = tick;
                                    last_next    = '0;
                                end
                            end else if (gate == owner_reg && !active) begin
                                running_next = 1'b0;
                                owner_next   = GATE_NONE;
                                if (dur >= {8'd0, min_ticks}) begin
                                    last_next = dur;
                                    store     = 1'b1;
                                end
                            end
                        end
                    end else if (mode == MODE_INTERVAL) begin
                        if (!gate[1] && active) begin
                            if (!running_reg) begin
                                running_next = 1'b1;
                                owner_next   = gate;
                                browse_next  = 1'b0;
                                start_next   = tick;
                                last_next    = '0;
                            end else if (gate != owner_reg) begin
                                last_next    = dur;
                                store        = 1'b1;
                                running_next = 1'b0;
                                owner_next   = gate;
                            end
                        end
                    end else if (active) begin
                        ecount_next  = ecount_reg + 32'd1;
                        running_next = 1'b1;
                    end
                end
            end
            OP_STOP: begin
                stopped_next = 1'b1;
                running_next = 1'b0;
            end
            OP_CLEAR: begin
                stopped_next = 1'b0;
                running_next = 1'b0;
                browse_next  = 1'b0;
                held_next    = '0;
                oldest_next  = '0;
                bidx_next    = '0;
                seq_next     = SEQ_START;
                last_next    = '0;
                ecount_next  = '0;
                owner_next   = GATE_NONE;
            end
            OP_BROWSE: begin
                if (!mode[1] && held_reg != '0) begin
                    if (!browse_reg || bidx_inc == held_reg) begin
                        bidx_next = '0;
                    end else begin
                        bidx_next = bidx_inc[HIST_AW-1:0];
                    end
                    browse_next  = 1'b1;
                    running_next = 1'b0;
                end
            end
            OP_RESUME: begin
                browse_next  = 1'b0;
                stopped_next = 1'b0;
            end
            default: begin
            end
        endcase

        // History append; the oldest entry is overwritten once full
        if (store) begin
            saved = 1'b1;
            if (held_reg < hist_cnt_t'(HIST_DEPTH)) begin
                waddr     = slot_of(oldest_reg, held_reg);
                held_next = held_reg + hist_cnt_t'(1);
            end else begin
                waddr       = oldest_reg;
                oldest_next = slot_of(oldest_reg, hist_cnt_t'(1));
            end
            held_less   = held_next - hist_cnt_t'(1);
            bidx_next   = held_less[HIST_AW-1:0];
            browse_next = 1'b0;
            if (seq_reg < SEQ_MAX) begin
                seq_next = seq_reg + 8'd1;
            end
        end
    end

    // Displayed value source: a browsed entry comes from the memory.
    // A store always clears browsing, so a read never targets the entry
    // written by the same transaction; later reads see the array already
    // updated, so no forwarding path is needed.
    always_comb begin
        use_mem = browse_next && held_next != '0 && hist_cnt_t'(bidx_next) < held_next;

        req.we    = in_fire && store;
        req.waddr = waddr;
        req.wdata = dur;
        req.re    = in_fire && use_mem;
        req.raddr = slot_of(oldest_next, hist_cnt_t'(bidx_next));

        res.running  = running_next;
        res.stopped  = stopped_next;
        res.browsing = browse_next;
        res.gate     = owner_next;
        res.shown    = mode[1] ? ecount_next : last_next;
        res.start    = start_next;
        res.count    = held_next;
        res.view     = bidx_next;
        res.seq      = seq_next;
        res.saved    = saved;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            stopped_reg <= 1'b0;
            browse_reg  <= 1'b0;
            owner_reg   <= GATE_NONE;
            start_reg   <= '0;
            last_reg    <= '0;
            ecount_reg  <= '0;
            oldest_reg  <= '0;
            held_reg    <= '0;
            bidx_reg    <= '0;
            seq_reg     <= SEQ_START;
        end else if (in_fire) begin
            running_reg <= running_next;
            stopped_reg <= stopped_next;
            browse_reg  <= browse_next;
            owner_reg   <= owner_next;
            start_reg   <= start_next;
            last_reg    <= last_next;
            ecount_reg  <= ecount_next;
            oldest_reg  <= oldest_next;
            held_reg    <= held_next;
            bidx_reg    <= bidx_next;
            seq_reg     <= seq_next;
        end
    end

endmodule

// File: rtl/core/ptimer_out.sv
module ptimer_out import ptimer_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_fire,
    input  result_t     res_in,
    input  logic        use_mem_in,
    input  logic [31:0] mem_q,
    input  logic        m_ready,
    output logic        in_ready,
    output logic        m_valid,
    output result_t     m_res
);

    logic    pipe_valid_reg, pipe_valid_next;
    result_t pipe_res_reg;
    logic    pipe_mem_reg;
    result_t pipe_out;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    logic    advance;

    // Pipe stage waits for the memory read; output register decouples m_tready
    always_comb begin
        advance  = pipe_valid_reg && (!out_valid_reg || m_ready);
        in_ready = !pipe_valid_reg || advance;

        pipe_valid_next = in_fire ? 1'b1 : (advance ? 1'b0 : pipe_valid_reg);
        out_valid_next  = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

        // Browsed entry replaces the shown value once the read data is back
        pipe_out = pipe_res_reg;
        if (pipe_mem_reg) begin
            pipe_out.shown = mem_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        if (in_fire) begin
            pipe_res_reg <= res_in;
            pipe_mem_reg <= use_mem_in;
        end
        if (advance) begin
            out_res_reg <= pipe_out;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_res_reg;

endmodule

// File: rtl/core/photogate_interval_timer_top.sv
// Path: an accepted transaction is registered in the pipe stage, then in the output register.
// Throughput: one transaction per cycle while m_tready is high; the history
// memory read issued at acceptance is picked up by the following pipe stage.
// Reset: synchronous, active-low aresetn clears flags, pointers and counters
// and the config registers (mode 0, minimum 600); history contents are not cleared.
module photogate_interval_timer_top import ptimer_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // s_tdata: gate_number[1:0], edge_active[2], edge_tick[34:3], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: operation[2:0]
    input  logic [2:0]             s_tuser,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // m_tdata: is_running, is_stopped, is_browsing, current_gate, shown_value,
    // run_start_tick, stored_count, view_index, sequence_number, result_saved, pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [1:0]  mode_reg;
    logic [23:0] min_reg;
    logic        cfg_wr;
    logic [0:0]  reg_idx;
    logic        in_fire;
    hist_req_t   req;
    result_t     res;
    result_t     m_res;
    logic        use_mem;
    logic [31:0] mem_q;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_BLOCK;
            min_reg  <= MIN_TICKS_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_MODE: mode_reg <= pwdata[1:0];
                REG_MIN:  min_reg  <= pwdata[23:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODE: prdata = {30'd0, mode_reg};
            REG_MIN:  prdata = {8'd0, min_reg};
            default:  prdata = '0;
        endcase
    end

    assign in_fire = s_tvalid && s_tready;

    ptimer_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .op        (s_tuser),
        .gate      (s_tdata[1:0]),
        .active    (s_tdata[2]),
        .tick      (s_tdata[34:3]),
        .mode      (mode_reg),
        .min_ticks (min_reg),
        .req       (req),
        .res       (res),
        .use_mem   (use_mem)
    );

    ptimer_hist_ram #(
        .DEPTH (HIST_DEPTH),
        .WIDTH (32)
    ) u_hist (
        .aclk  (aclk),
        .we    (req.we),
        .waddr (req.waddr),
        .wdata (req.wdata),
        .re    (req.re),
        .raddr (req.raddr),
        .rdata (mem_q)
    );

    ptimer_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_fire    (in_fire),
        .res_in     (res),
        .use_mem_in (use_mem),
        .mem_q      (mem_q),
        .m_ready    (m_tready),
        .in_ready   (s_tready),
        .m_valid    (m_tvalid),
        .m_res      (m_res)
    );

    // Pack result fields, lowest first
    assign m_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                      m_res.saved, m_res.seq, m_res.view, m_res.count,
                      m_res.start, m_res.shown, m_res.gate,
                      m_res.browsing, m_res.stopped, m_res.running};

endmodule

// File: rtl/core/ptimer_checker.sv
`include "photogate_interval_timer_top_assert.svh"

module ptimer_checker import ptimer_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready
);

    // A stalled result holds its payload
    `PTIMER_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Input back-pressure only while a result is pending
    `PTIMER_ASSERT_NOW(a_ready_only_full, !s_tready, m_tvalid, "input stalled with empty output")

    // A new history entry always ends browsing
    `PTIMER_ASSERT_NOW(a_saved_not_browse, m_tvalid, !(m_tdata[OB_SAVED] && m_tdata[OB_BRW]), "saved while browsing")

    // Stop state never reports a running measurement
    `PTIMER_ASSERT_NOW(a_run_stop_excl, m_tvalid, !(m_tdata[OB_RUN] && m_tdata[OB_STOP]), "running while stopped")

endmodule

bind photogate_interval_timer_top ptimer_checker u_ptimer_checker (.*);
